// ===== rtl/core/khq_pkg.sv =====
package khq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam int KEY_W = 8;
  localparam int REG_W = 8;
  localparam int CFG_ADDR_W = 2;
  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;

  localparam logic [REG_W-1:0] INVALID_CODE_RST = 8'd255;
  localparam logic [REG_W-1:0] TRANSMIT_CODE_RST = 8'd0;
  localparam logic [REG_W-1:0] SHORT_POLLS_RST = 8'd3;
  localparam logic [REG_W-1:0] LONG_POLLS_RST = 8'd41;
  localparam logic [7:0] HOLD_MAX = 8'd255;

  typedef enum logic [2:0] {
    FUNC_POLL       = 3'd0,
    FUNC_INJ_SHORT  = 3'd1,
    FUNC_INJ_LONG   = 3'd2,
    FUNC_PRESS      = 3'd3,
    FUNC_RELEASE    = 3'd4,
    FUNC_QUERY      = 3'd5
  } func_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_INVALID_CODE  = 2'd0,
    CFG_TRANSMIT_CODE = 2'd1,
    CFG_SHORT_POLLS   = 2'd2,
    CFG_LONG_POLLS    = 2'd3
  } cfg_idx_t;

  // queue requests from the control logic
  typedef struct packed {
    logic             push;
    logic             push_long;
    logic [KEY_W-1:0] push_key;
    logic             pop;
  } q_cmd_t;

  // queue head and fill status
  typedef struct packed {
    logic             empty;
    logic             head_long;
    logic [KEY_W-1:0] head_key;
  } q_stat_t;

  typedef struct packed {
    logic             accepted;
    logic             held;
    logic             from_serial;
    logic [KEY_W-1:0] key_out;
  } result_t;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    begin
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
        n = '0;
      end else begin
        n = p + PTR_W'(1);
      end
      return n;
    end
  endfunction

endpackage

// ===== rtl/core/injected_key_hold_queue_core.sv =====
// Injected key hold queue.
// Slave stream (s_*) carries commands: poll, inject short/long, press,
// release, query. Every accepted word yields exactly one result word on
// the master stream (m_*). Config registers are written through
// cfg_we/cfg_addr/cfg_data: 0 invalid code, 1 transmit code, 2 short polls,
// 3 long polls; write only while no command is in flight.
// A word accepted on s_* is held in the input register, is processed, and
// the result register then drives it on m_tvalid/m_tdata.
// Throughput: one word per cycle unless m_tready stalls the result register;
// all queue and counter work is combinational between the input and result registers.
// Reset (rst, synchronous) empties the queue, clears the active key and
// restores the config defaults; the entry store itself is not cleared.
// When m_tready is low the result register holds; one more word is taken
// into the input register, then s_tready drops until the result drains.
module injected_key_hold_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [2:0] func, [10:3] key_code, [11] is_long, [15:12] zero
  input  logic [khq_pkg::S_DATA_W-1:0]     s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] key_out, [8] from_serial, [9] held, [10] accepted, [15:11] zero
  output logic [khq_pkg::M_DATA_W-1:0]     m_tdata,
  input  logic                             cfg_we,
  input  logic [khq_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [khq_pkg::REG_W-1:0]        cfg_data
);

  logic                      in_valid;
  logic [2:0]                in_func;
  logic [khq_pkg::KEY_W-1:0] in_key;
  logic                      in_long;
  logic                      out_valid;
  khq_pkg::result_t          out_res;
  logic                      go;
  khq_pkg::q_cmd_t           qcmd;
  khq_pkg::q_stat_t          qstat;
  khq_pkg::result_t          res;

  assign go = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (go) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tdata[2:0];
      in_key <= s_tdata[10:3];
      in_long <= s_tdata[11];
    end
  end

  khq_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (qcmd),
    .stat (qstat)
  );

  khq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .go       (go),
    .func     (in_func),
    .key_code (in_key),
    .is_long  (in_long),
    .qstat    (qstat),
    .qcmd     (qcmd),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {5'd0, out_res.accepted, out_res.held, out_res.from_serial,
                    out_res.key_out};

endmodule

// ===== rtl/core/khq_queue.sv =====
module khq_queue (
  input  logic            clk,
  input  logic            rst,
  input  khq_pkg::q_cmd_t cmd,
  output khq_pkg::q_stat_t stat
);

  logic [khq_pkg::KEY_W:0]   store [khq_pkg::QUEUE_DEPTH];
  logic [khq_pkg::PTR_W-1:0] write_pointer;
  logic [khq_pkg::PTR_W-1:0] read_pointer;
  logic [khq_pkg::PTR_W-1:0] write_pointer_next;
  logic [khq_pkg::PTR_W-1:0] read_pointer_next;
  logic [khq_pkg::PTR_W-1:0] wp_inc;

  assign wp_inc = khq_pkg::next_ptr(write_pointer);

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next = read_pointer;
    if (cmd.push) begin
      write_pointer_next = wp_inc;
      // full: drop the oldest entry
      if (wp_inc == read_pointer) begin
        read_pointer_next = khq_pkg::next_ptr(read_pointer);
      end
    end else if (cmd.pop) begin
      read_pointer_next = khq_pkg::next_ptr(read_pointer);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer <= '0;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer <= read_pointer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      store[write_pointer] <= {cmd.push_long, cmd.push_key};
    end
  end

  always_comb begin
    stat.empty = (read_pointer == write_pointer);
    stat.head_long = store[read_pointer][khq_pkg::KEY_W];
    stat.head_key = store[read_pointer][khq_pkg::KEY_W-1:0];
  end

endmodule

// ===== rtl/core/khq_ctrl.sv =====
module khq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [khq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [khq_pkg::REG_W-1:0]      cfg_data,
  input  logic                           go,
  input  logic [2:0]                     func,
  input  logic [khq_pkg::KEY_W-1:0]      key_code,
  input  logic                           is_long,
  input  khq_pkg::q_stat_t               qstat,
  output khq_pkg::q_cmd_t                qcmd,
  output khq_pkg::result_t               res
);

  logic [khq_pkg::REG_W-1:0] invalid_code;
  logic [khq_pkg::REG_W-1:0] transmit_code;
  logic [khq_pkg::REG_W-1:0] short_polls;
  logic [khq_pkg::REG_W-1:0] long_polls;

  logic [khq_pkg::KEY_W-1:0] active_key;
  logic [7:0]                hold_count;
  logic                      active_long;
  logic                      forced_down;
  logic [khq_pkg::KEY_W-1:0] active_key_next;
  logic [7:0]                hold_count_next;
  logic                      active_long_next;
  logic                      forced_down_next;

  logic                      ok;
  logic                      take;
  logic [khq_pkg::KEY_W-1:0] key_a;
  logic                      long_a;
  logic [7:0]                cnt_a;
  logic [7:0]                cnt_inc;
  logic [7:0]                thr;
  logic                      present;

  always_ff @(posedge clk) begin
    if (rst) begin
      invalid_code <= khq_pkg::INVALID_CODE_RST;
      transmit_code <= khq_pkg::TRANSMIT_CODE_RST;
      short_polls <= khq_pkg::SHORT_POLLS_RST;
      long_polls <= khq_pkg::LONG_POLLS_RST;
    end else if (cfg_we) begin
      case (khq_pkg::cfg_idx_t'(cfg_addr))
        khq_pkg::CFG_INVALID_CODE:  invalid_code <= cfg_data;
        khq_pkg::CFG_TRANSMIT_CODE: transmit_code <= cfg_data;
        khq_pkg::CFG_SHORT_POLLS:   short_polls <= cfg_data;
        khq_pkg::CFG_LONG_POLLS:    long_polls <= cfg_data;
        default: ;
      endcase
    end
  end

  // poll path: optionally load the queue head, then count against threshold
  assign ok = key_code < invalid_code;
  assign take = !forced_down && !(active_key < invalid_code) && !qstat.empty;
  assign key_a = take ? qstat.head_key : active_key;
  assign long_a = take ? qstat.head_long : active_long;
  assign cnt_a = take ? 8'd0 : hold_count;
  assign present = key_a < invalid_code;
  assign cnt_inc = (cnt_a == khq_pkg::HOLD_MAX) ? cnt_a : cnt_a + 8'd1;

  always_comb begin
    if (long_a && key_a != transmit_code) begin
      thr = long_polls;
    end else begin
      thr = short_polls;
    end
  end

  always_comb begin
    active_key_next = active_key;
    hold_count_next = hold_count;
    active_long_next = active_long;
    forced_down_next = forced_down;
    res.key_out = invalid_code;
    res.from_serial = 1'b0;
    res.held = 1'b0;
    res.accepted = 1'b0;
    qcmd.push = 1'b0;
    qcmd.push_long = 1'b0;
    qcmd.push_key = key_code;
    qcmd.pop = 1'b0;
    case (khq_pkg::func_t'(func))
      khq_pkg::FUNC_POLL: begin
        qcmd.pop = go && take;
        if (take) begin
          active_key_next = key_a;
          active_long_next = long_a;
          hold_count_next = 8'd0;
        end
        if (present) begin
          res.key_out = key_a;
          res.from_serial = 1'b1;
          if (!forced_down) begin
            if (cnt_inc >= thr) begin
              active_key_next = invalid_code;
              hold_count_next = 8'd0;
              active_long_next = 1'b0;
            end else begin
              hold_count_next = cnt_inc;
            end
          end
        end
      end
      khq_pkg::FUNC_INJ_SHORT, khq_pkg::FUNC_INJ_LONG: begin
        res.accepted = ok;
        qcmd.push = go && ok;
        qcmd.push_long = (khq_pkg::func_t'(func) == khq_pkg::FUNC_INJ_LONG);
      end
      khq_pkg::FUNC_PRESS: begin
        res.accepted = ok;
        if (ok) begin
          active_key_next = key_code;
          active_long_next = is_long;
          hold_count_next = 8'd0;
          forced_down_next = 1'b1;
        end
      end
      khq_pkg::FUNC_RELEASE: begin
        if (ok && forced_down && active_key == key_code) begin
          active_key_next = invalid_code;
          active_long_next = 1'b0;
          hold_count_next = 8'd0;
          forced_down_next = 1'b0;
        end
      end
      khq_pkg::FUNC_QUERY: begin
        res.held = forced_down && (active_key == key_code);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_key <= khq_pkg::INVALID_CODE_RST;
      hold_count <= 8'd0;
      active_long <= 1'b0;
      forced_down <= 1'b0;
    end else if (go) begin
      active_key <= active_key_next;
      hold_count <= hold_count_next;
      active_long <= active_long_next;
      forced_down <= forced_down_next;
    end
  end

endmodule

// ===== rtl/core/khq_checker.sv =====
module khq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [khq_pkg::M_DATA_W-1:0]   m_tdata
);

  // nothing in flight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:11] == 5'd0)
    else $error("result padding bits not zero");

  // poll, query and inject/press flags are mutually exclusive
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[10:8]) <= 1)
    else $error("more than one result flag set");

  // a result word after an empty output register needs a word accepted earlier, through the input register
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a processed word");

endmodule

bind injected_key_hold_queue_core khq_checker u_khq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/tb_injected_key_hold_queue_core.sv =====
module tb_injected_key_hold_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import khq_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;

  // func codes the block treats as no-ops
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  localparam result_t IDLE_RES = '{accepted: 1'b0, held: 1'b0, from_serial: 1'b0,
                                   key_out: 8'hFF};
  localparam result_t ACC_RES  = '{accepted: 1'b1, held: 1'b0, from_serial: 1'b0,
                                   key_out: 8'hFF};
  localparam result_t HELD_RES = '{accepted: 1'b0, held: 1'b1, from_serial: 1'b0,
                                   key_out: 8'hFF};

  typedef struct packed {
    logic [2:0] fn;
    logic [7:0] key;
    logic       lng;
    logic       typed;
    result_t    want;
  } dir_row_t;

  // reset config: invalid 255, transmit 0, short 3, long 41
  localparam dir_row_t DIR_ROWS [25] = '{
    '{FUNC_POLL,      8'h00, 1'b0, 1'b1, IDLE_RES},  // empty queue, nothing active
    '{FUNC_QUERY,     8'h00, 1'b1, 1'b1, IDLE_RES},
    '{FUNC_RELEASE,   8'h00, 1'b0, 1'b1, IDLE_RES},
    '{FUNC_INJ_SHORT, 8'hFF, 1'b0, 1'b1, IDLE_RES},  // code at invalid is rejected
    '{FUNC_INJ_LONG,  8'hFF, 1'b1, 1'b1, IDLE_RES},
    '{FUNC_PRESS,     8'hFF, 1'b1, 1'b1, IDLE_RES},
    '{FUNC_INJ_SHORT, 8'h00, 1'b0, 1'b1, ACC_RES},
    '{FUNC_INJ_LONG,  8'hFE, 1'b1, 1'b1, ACC_RES},
    '{FUNC_INJ_LONG,  8'h00, 1'b0, 1'b1, ACC_RES},   // long press on transmit key
    '{FUNC_POLL,      8'h37, 1'b1, 1'b0, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_PRESS,     8'hA5, 1'b1, 1'b1, ACC_RES},   // press replaces the active key
    '{FUNC_QUERY,     8'hA5, 1'b0, 1'b1, HELD_RES},
    '{FUNC_QUERY,     8'h5A, 1'b0, 1'b1, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_RELEASE,   8'h5A, 1'b1, 1'b1, IDLE_RES},  // other key: ignored
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_RELEASE,   8'hA5, 1'b0, 1'b1, IDLE_RES},
    '{FUNC_QUERY,     8'hA5, 1'b0, 1'b1, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES},
    '{FUNC_SPARE_6,   8'hFF, 1'b1, 1'b1, IDLE_RES},
    '{FUNC_SPARE_7,   8'h5A, 1'b0, 1'b1, IDLE_RES},
    '{FUNC_POLL,      8'h00, 1'b0, 1'b0, IDLE_RES}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [REG_W-1:0]      cfg_data = '0;

  injected_key_hold_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [8:0] slot_mem [QUEUE_DEPTH];
  int         wr_idx;
  int         rd_idx;
  logic [7:0] cur_key;
  logic [7:0] hold_cnt;
  logic       cur_long;
  logic       forced;
  logic [7:0] no_key_code;
  logic [7:0] tx_code;
  logic [7:0] short_thr;
  logic [7:0] long_thr;

  result_t    key_reports_q [$];
  int         err_cnt = 0;
  int         cyc = 0;
  bit         quiet = 1'b0;
  bit         hold_req = 1'b0;
  logic [7:0] last_press = 8'h00;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic void clear_key_state();
    wr_idx      = 0;
    rd_idx      = 0;
    cur_key     = 8'hFF;
    hold_cnt    = '0;
    cur_long    = 1'b0;
    forced      = 1'b0;
    no_key_code = INVALID_CODE_RST;
    tx_code     = TRANSMIT_CODE_RST;
    short_thr   = SHORT_POLLS_RST;
    long_thr    = LONG_POLLS_RST;
  endfunction

  function automatic result_t predict_key_report(input logic [2:0] fn,
                                                 input logic [7:0] key,
                                                 input logic lng);
    result_t    r;
    logic [8:0] ent;
    logic [7:0] thr;
    logic       ok;
    int         nxt;
    r = '{accepted: 1'b0, held: 1'b0, from_serial: 1'b0, key_out: no_key_code};
    ok = key < no_key_code;
    case (fn)
      FUNC_POLL: begin
        if (!forced && !(cur_key < no_key_code) && rd_idx != wr_idx) begin
          ent = slot_mem[rd_idx];
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          cur_key = ent[7:0];
          cur_long = ent[8];
          hold_cnt = '0;
        end
        // a stale entry (now >= invalid) leaves nothing to report
        if (cur_key < no_key_code) begin
          thr = cur_long ? long_thr : short_thr;
          if (cur_long && cur_key == tx_code) thr = short_thr;
          r.key_out = cur_key;
          r.from_serial = 1'b1;
          if (!forced) begin
            if (hold_cnt < 8'd255) hold_cnt = hold_cnt + 8'd1;
            if (hold_cnt >= thr) begin
              cur_key = no_key_code;
              hold_cnt = '0;
              cur_long = 1'b0;
            end
          end
        end
      end
      FUNC_INJ_SHORT, FUNC_INJ_LONG: begin
        r.accepted = ok;
        if (ok) begin
          nxt = (wr_idx + 1) % QUEUE_DEPTH;
          // full ring: oldest entry is dropped
          if (nxt == rd_idx) rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          slot_mem[wr_idx] = {(fn == FUNC_INJ_LONG), key};
          wr_idx = nxt;
        end
      end
      FUNC_PRESS: begin
        r.accepted = ok;
        if (ok) begin
          cur_key = key;
          cur_long = lng;
          hold_cnt = '0;
          forced = 1'b1;
        end
      end
      FUNC_RELEASE: begin
        if (ok && forced && cur_key == key) begin
          cur_key = no_key_code;
          cur_long = 1'b0;
          hold_cnt = '0;
          forced = 1'b0;
        end
      end
      FUNC_QUERY: r.held = forced && cur_key == key;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] pick_func();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return FUNC_POLL;
    if (r < 55) return FUNC_INJ_SHORT;
    if (r < 70) return FUNC_INJ_LONG;
    if (r < 77) return FUNC_PRESS;
    if (r < 85) return FUNC_RELEASE;
    if (r < 95) return FUNC_QUERY;
    if (r < 97) return FUNC_SPARE_6;
    return FUNC_SPARE_7;
  endfunction

  function automatic logic [7:0] pick_key(input logic [2:0] fn);
    if ((fn == FUNC_RELEASE || fn == FUNC_QUERY) && $urandom_range(0, 1))
      return last_press;
    case ($urandom_range(0, 9))
      0, 1:       return tx_code;
      2, 3, 4, 5,
      6:          return 8'($urandom_range(0, int'(no_key_code) - 1));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_cmd(input logic [2:0] fn, input logic [7:0] key, input logic lng,
                          input logic typed, input result_t want);
    result_t pred;
    s_tdata  <= {4'b0000, lng, key, fn};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = predict_key_report(fn, key, lng);
    key_reports_q.push_back(typed ? want : pred);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic run_random(input int n_items, input bit with_hold, input bit quiet_tail);
    logic [2:0] fn;
    logic [7:0] key;
    logic       lng;
    int         burst;
    burst = $urandom_range(0, 40);  // long bursts overrun the ring
    for (int i = 0; i < n_items; i++) begin
      if (i < burst) fn = $urandom_range(0, 1) ? FUNC_INJ_LONG : FUNC_INJ_SHORT;
      else fn = pick_func();
      key = pick_key(fn);
      lng = $urandom_range(0, 1);
      if (fn == FUNC_PRESS) last_press = key;
      if (with_hold && i == 60) hold_req = 1'b1;
      if (quiet_tail && i == n_items / 2) quiet = 1'b1;
      send_cmd(fn, key, lng, 1'b0, IDLE_RES);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (key_reports_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_INVALID_CODE:  no_key_code = v;
      CFG_TRANSMIT_CODE: tx_code = v;
      CFG_SHORT_POLLS:   short_thr = v;
      CFG_LONG_POLLS:    long_thr = v;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [7:0] inv, input logic [7:0] tx,
                             input logic [7:0] sh, input logic [7:0] lg);
    write_reg(CFG_INVALID_CODE, inv);
    write_reg(CFG_TRANSMIT_CODE, tx);
    write_reg(CFG_SHORT_POLLS, sh);
    write_reg(CFG_LONG_POLLS, lg);
    cfg_we <= 1'b0;
  endtask

  // receiver: random stalls, one long hold-off on request, none at the tail
  initial begin : rx_ctl
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[10:0]);
      if (key_reports_q.size() == 0) begin
        report_mismatch("unexpected result word, key_out", got.key_out, 0);
      end else begin
        want = key_reports_q.pop_front();
        if (got.key_out != want.key_out)
          report_mismatch("key_out", got.key_out, want.key_out);
        if (got.from_serial != want.from_serial)
          report_mismatch("from_serial", got.from_serial, want.from_serial);
        if (got.held != want.held)
          report_mismatch("held", got.held, want.held);
        if (got.accepted != want.accepted)
          report_mismatch("accepted", got.accepted, want.accepted);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : stim
    logic [7:0] inv;
    clear_key_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[i])
      send_cmd(DIR_ROWS[i].fn, DIR_ROWS[i].key, DIR_ROWS[i].lng,
               DIR_ROWS[i].typed, DIR_ROWS[i].want);
    run_random(190, 1'b0, 1'b0);

    // queued codes at or above the new invalid code go stale here
    drain();
    load_config(8'd1, 8'd0, 8'd1, 8'd1);
    run_random(190, 1'b0, 1'b0);

    drain();
    load_config(8'd255, 8'd254, 8'd255, 8'd255);
    run_random(190, 1'b0, 1'b0);

    drain();
    inv = 8'($urandom_range(2, 255));
    load_config(inv, 8'($urandom_range(0, int'(inv) - 1)),
                8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
    run_random(190, 1'b0, 1'b0);

    drain();
    load_config(8'd128, 8'd127, 8'd2, 8'd5);
    run_random(190, 1'b1, 1'b0);

    drain();
    load_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(1, 20)), 8'($urandom_range(1, 60)));
    run_random(190, 1'b0, 1'b1);

    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== injected_key_hold_queue_core.f =====
rtl/core/khq_pkg.sv
rtl/core/khq_queue.sv
rtl/core/khq_ctrl.sv
rtl/core/injected_key_hold_queue_core.sv
rtl/core/khq_checker.sv
dv/tb_injected_key_hold_queue_core.sv
